[src/bhte_pkg.sv]
package bhte_pkg;

	localparam int KEY_BITS = 64;

	localparam logic [1:0] CMD_GET = 2'd0;
	localparam logic [1:0] CMD_PUT = 2'd1;
	localparam logic [1:0] CMD_DEL = 2'd2;
	localparam logic [1:0] CMD_CLR = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [1:0] SL_EMPTY = 2'd0;
	localparam logic [1:0] SL_OCC   = 2'd1;
	localparam logic [1:0] SL_TOMB  = 2'd2;

	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int          MIX_SHIFT = 33;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] key;
		logic [63:0] record_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] record_out;
		logic [11:0] entries;
	} rsp_t;

endpackage

[src/bhte_hash.sv]
module bhte_hash #(
	parameter int TOTAL_BUCKETS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [63:0]                          key,
	input  logic [$clog2(TOTAL_BUCKETS+1)-1:0]   nb,
	output logic                                 done,
	output logic [$clog2(TOTAL_BUCKETS)-1:0]     bucket
);

	localparam int BW  = $clog2(TOTAL_BUCKETS);
	localparam int NBW = $clog2(TOTAL_BUCKETS + 1);

	localparam logic [1:0] H_IDLE = 2'd0;
	localparam logic [1:0] H_MUL  = 2'd1;
	localparam logic [1:0] H_MOD  = 2'd2;

	logic [1:0]  state_q;
	logic [63:0] h_q;
	logic [63:0] acc_q;
	logic        ph_q;
	logic [1:0]  ms_q;
	logic [5:0]  bit_q;
	logic [BW-1:0] rem_q;
	logic        done_q;
	logic [BW-1:0] bucket_q;

	logic [63:0] c;
	logic [31:0] op_a, op_b;
	logic [63:0] prod;
	logic [63:0] sum;
	logic [BW:0]  trial;
	logic [BW-1:0] rem_next;

	always_comb begin
		c = ph_q ? bhte_pkg::MIX_C2 : bhte_pkg::MIX_C1;
		op_a = (ms_q == 2'd2) ? h_q[63:32] : h_q[31:0];
		op_b = (ms_q == 2'd1) ? c[63:32] : c[31:0];
		prod = 64'(op_a) * 64'(op_b);
		sum = acc_q + {prod[31:0], 32'd0};
		trial = {rem_q, h_q[63]};
		if ((NBW+1)'(trial) >= (NBW+1)'(nb))
			rem_next = BW'((NBW+1)'(trial) - (NBW+1)'(nb));
		else
			rem_next = BW'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				H_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						h_q     <= key ^ (key >> bhte_pkg::MIX_SHIFT);
						ph_q    <= 1'b0;
						ms_q    <= 2'd0;
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					case (ms_q)
						2'd0: begin
							acc_q <= prod;
							ms_q  <= 2'd1;
						end
						2'd1: begin
							acc_q <= sum;
							ms_q  <= 2'd2;
						end
						default: begin
							h_q  <= sum ^ (sum >> bhte_pkg::MIX_SHIFT);
							ms_q <= 2'd0;
							if (ph_q) begin
								state_q <= H_MOD;
								bit_q   <= 6'd63;
								rem_q   <= '0;
							end else begin
								ph_q <= 1'b1;
							end
						end
					endcase
				end
				H_MOD: begin
					rem_q <= rem_next;
					h_q   <= h_q << 1;
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd0) begin
						bucket_q <= rem_next;
						done_q   <= 1'b1;
						state_q  <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign bucket = bucket_q;

endmodule

[src/bucket_hash_table_engine.sv]
// hashing runs fmix64 on one 32x32 multiplier, then a one-bit-per-cycle modulo;
// then each visited bucket is read and scanned slot by slot, and a write-back
// follows where needed; one command at a time, busy covers all of it
// clear writes one slot-state row and link per cycle
// after reset the same clearing pass runs with busy high; no result is given for it
// the receiver cannot stall: done marks the single result cycle
module bucket_hash_table_engine #(
	parameter int TOTAL_BUCKETS = 256,
	parameter int BUCKET_SLOTS  = 8,
	parameter int RECORD_BITS   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bhte_pkg::req_t    req,
	output logic              done,
	output bhte_pkg::rsp_t    rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [8:0]        cfg_data
);

	localparam int BW  = $clog2(TOTAL_BUCKETS);
	localparam int NBW = $clog2(TOTAL_BUCKETS + 1);
	localparam int SW  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int CW  = $clog2(BUCKET_SLOTS + 1);
	localparam int NS  = TOTAL_BUCKETS * BUCKET_SLOTS;
	localparam int IW  = (NS > 1) ? $clog2(NS) : 1;
	localparam int ETW = $clog2(NS + 1);
	localparam int RW  = 2 * BUCKET_SLOTS;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_HASH = 4'd2;
	localparam logic [3:0] S_RDB  = 4'd3;
	localparam logic [3:0] S_SLOT = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_NEXT = 4'd6;
	localparam logic [3:0] S_DEC  = 4'd7;
	localparam logic [3:0] S_WRD  = 4'd8;
	localparam logic [3:0] S_WWR  = 4'd9;
	localparam logic [3:0] S_NRD  = 4'd10;
	localparam logic [3:0] S_NWR  = 4'd11;
	localparam logic [3:0] S_NLK  = 4'd12;

	logic [3:0]             state_q;
	logic [8:0]             cfg_q;
	logic [BW-1:0]          clr_q;
	logic                   clr_rsp_q;
	logic [1:0]             cmd_q;
	logic [63:0]            key_q;
	logic [RECORD_BITS-1:0] rin_q;
	logic [BW-1:0]          b_q;
	logic [SW-1:0]          s_q;
	logic [NBW-1:0]         hop_q;
	logic                   have_free_q;
	logic [BW-1:0]          fb_q;
	logic [SW-1:0]          fs_q;
	logic [BW-1:0]          tb_q;
	logic [SW-1:0]          ts_q;
	logic [1:0]             code_q;
	logic                   wkey_q;
	logic                   inc_q;
	logic                   dec_q;
	logic [ETW-1:0]         et_q;
	logic [NBW-1:0]         ovf_q;
	logic                   done_q;
	bhte_pkg::rsp_t         rsp_q;

	logic [RW-1:0]          st_mem [TOTAL_BUCKETS];
	logic [BW-1:0]          nx_mem [TOTAL_BUCKETS];
	logic [63:0]            key_mem [NS];
	logic [RECORD_BITS-1:0] rec_mem [NS];

	logic [RW-1:0]          st_rd;
	logic [BW-1:0]          nx_rd;
	logic [63:0]            key_rd;
	logic [RECORD_BITS-1:0] rec_rd;

	logic                   st_re;
	logic [BW-1:0]          st_raddr;
	logic                   st_we;
	logic [BW-1:0]          st_waddr;
	logic [RW-1:0]          st_wdata;
	logic                   nx_we;
	logic [BW-1:0]          nx_waddr;
	logic [BW-1:0]          nx_wdata;
	logic                   kr_we;
	logic                   kw_en;
	logic [IW-1:0]          kr_raddr;
	logic [IW-1:0]          kr_waddr;

	logic                   h_start;
	logic                   h_done;
	logic [BW-1:0]          h_bucket;
	logic [NBW-1:0]         nb;
	logic [NBW:0]           nid;
	logic [1:0]             cur_code;
	logic                   hit;
	logic                   slot_last;
	logic [NBW-1:0]         hop_next;
	logic [RW-1:0]          row_mod;
	logic [RW-1:0]          row_new;
	logic [CW-1:0]          occ_cnt;
	logic [ETW-1:0]         et_wipe;

	always_comb begin
		if (cfg_q == 9'd0)
			nb = NBW'(1);
		else if (32'(cfg_q) > 32'(TOTAL_BUCKETS))
			nb = NBW'(TOTAL_BUCKETS);
		else
			nb = NBW'(cfg_q);
		nid       = (NBW+1)'(nb) + (NBW+1)'(ovf_q);
		cur_code  = st_rd[{s_q, 1'b0} +: 2];
		hit       = (cur_code == bhte_pkg::SL_OCC) && (key_rd == key_q);
		slot_last = (s_q == SW'(BUCKET_SLOTS - 1));
		hop_next  = hop_q + NBW'(1);
		kr_raddr  = IW'(IW'(b_q) * IW'(BUCKET_SLOTS) + IW'(s_q));
		kr_waddr  = IW'(IW'(tb_q) * IW'(BUCKET_SLOTS) + IW'(ts_q));
		row_mod = st_rd;
		row_mod[{ts_q, 1'b0} +: 2] = code_q;
		row_new = '0;
		row_new[1:0] = bhte_pkg::SL_OCC;
		occ_cnt = '0;
		for (int i = 0; i < BUCKET_SLOTS; i++) begin
			if (st_rd[2*i +: 2] == bhte_pkg::SL_OCC)
				occ_cnt = occ_cnt + CW'(1);
		end
		if (et_q > ETW'(occ_cnt))
			et_wipe = et_q - ETW'(occ_cnt) + ETW'(1);
		else
			et_wipe = ETW'(1);
	end

	// memory port control
	always_comb begin
		st_re    = 1'b0;
		st_raddr = b_q;
		st_we    = 1'b0;
		st_waddr = tb_q;
		st_wdata = row_mod;
		nx_we    = 1'b0;
		nx_waddr = tb_q;
		nx_wdata = '0;
		kr_we    = 1'b0;
		kw_en    = 1'b0;
		case (state_q)
			S_CLR: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
				st_wdata = '0;
				nx_we    = 1'b1;
				nx_waddr = clr_q;
			end
			S_RDB: st_re = 1'b1;
			S_WRD, S_NRD: begin
				st_re    = 1'b1;
				st_raddr = tb_q;
			end
			S_WWR: begin
				st_we = 1'b1;
				kr_we = 1'b1;
				kw_en = wkey_q;
			end
			S_NWR: begin
				st_we    = 1'b1;
				st_wdata = row_new;
				nx_we    = 1'b1;
				kr_we    = 1'b1;
				kw_en    = 1'b1;
			end
			S_NLK: begin
				nx_we    = 1'b1;
				nx_waddr = b_q;
				nx_wdata = tb_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we)
			st_mem[st_waddr] <= st_wdata;
		if (st_re)
			st_rd <= st_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (nx_we)
			nx_mem[nx_waddr] <= nx_wdata;
		if (st_re)
			nx_rd <= nx_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (kr_we && kw_en)
			key_mem[kr_waddr] <= key_q;
		key_rd <= key_mem[kr_raddr];
	end

	always_ff @(posedge clk) begin
		if (kr_we)
			rec_mem[kr_waddr] <= rin_q;
		rec_rd <= rec_mem[kr_raddr];
	end

	assign h_start = (state_q == S_IDLE) && start && (req.command != bhte_pkg::CMD_CLR);

	bhte_hash #(
		.TOTAL_BUCKETS(TOTAL_BUCKETS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (h_start),
		.key   (req.key),
		.nb    (nb),
		.done  (h_done),
		.bucket(h_bucket)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_q <= 9'd1;
		else if (cfg_valid && cfg_ready)
			cfg_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_rsp_q   <= 1'b0;
			et_q        <= '0;
			ovf_q       <= '0;
			done_q      <= 1'b0;
			have_free_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(TOTAL_BUCKETS - 1)) begin
						et_q    <= '0;
						ovf_q   <= '0;
						state_q <= S_IDLE;
						if (clr_rsp_q) begin
							done_q <= 1'b1;
							rsp_q  <= '{status: bhte_pkg::ST_OK, record_out: 64'd0, entries: 12'd0};
						end
					end
				end
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						cmd_q <= req.command;
						key_q <= req.key;
						rin_q <= req.record_in[RECORD_BITS-1:0];
						if (req.command == bhte_pkg::CMD_CLR) begin
							clr_q     <= '0;
							clr_rsp_q <= 1'b1;
							state_q   <= S_CLR;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (h_done) begin
						b_q         <= h_bucket;
						hop_q       <= '0;
						have_free_q <= 1'b0;
						state_q     <= S_RDB;
					end
				end
				S_RDB: begin
					s_q     <= '0;
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					if (cur_code == bhte_pkg::SL_OCC) begin
						state_q <= S_CMP;
					end else begin
						if (!have_free_q && (cur_code == bhte_pkg::SL_EMPTY ||
								cur_code == bhte_pkg::SL_TOMB)) begin
							have_free_q <= 1'b1;
							fb_q        <= b_q;
							fs_q        <= s_q;
						end
						if (slot_last)
							state_q <= S_NEXT;
						else
							s_q <= s_q + SW'(1);
					end
				end
				S_CMP: begin
					if (key_rd == key_q) begin
						state_q <= S_DEC;
					end else if (slot_last) begin
						state_q <= S_NEXT;
					end else begin
						s_q     <= s_q + SW'(1);
						state_q <= S_SLOT;
					end
				end
				S_NEXT: begin
					if (nx_rd == '0 || 32'(nx_rd) >= 32'(TOTAL_BUCKETS) ||
							32'(hop_next) >= 32'(TOTAL_BUCKETS)) begin
						state_q <= S_DEC;
					end else begin
						b_q     <= nx_rd;
						hop_q   <= hop_next;
						state_q <= S_RDB;
					end
				end
				S_DEC: begin
					// walk ends on the matching slot or on the last slot visited
					rsp_q.entries    <= 12'(et_q);
					rsp_q.record_out <= (hit && cmd_q == bhte_pkg::CMD_GET) ?
						64'(rec_rd) : 64'd0;
					if (hit) begin
						tb_q   <= b_q;
						ts_q   <= s_q;
						wkey_q <= 1'b0;
						inc_q  <= 1'b0;
						case (cmd_q)
							bhte_pkg::CMD_GET: begin
								rsp_q.status <= bhte_pkg::ST_OK;
								done_q       <= 1'b1;
								state_q      <= S_IDLE;
							end
							bhte_pkg::CMD_DEL: begin
								code_q  <= bhte_pkg::SL_TOMB;
								dec_q   <= 1'b1;
								state_q <= S_WRD;
							end
							default: begin
								code_q  <= bhte_pkg::SL_OCC;
								dec_q   <= 1'b0;
								state_q <= S_WRD;
							end
						endcase
					end else if (cmd_q != bhte_pkg::CMD_PUT) begin
						rsp_q.status <= bhte_pkg::ST_NOTFOUND;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else if (have_free_q) begin
						tb_q    <= fb_q;
						ts_q    <= fs_q;
						code_q  <= bhte_pkg::SL_OCC;
						wkey_q  <= 1'b1;
						inc_q   <= 1'b1;
						dec_q   <= 1'b0;
						state_q <= S_WRD;
					end else if (32'(nid) >= 32'(TOTAL_BUCKETS)) begin
						rsp_q.status <= bhte_pkg::ST_FULL;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						tb_q    <= BW'(nid);
						ts_q    <= '0;
						state_q <= S_NRD;
					end
				end
				S_WRD: state_q <= S_WWR;
				S_WWR: begin
					if (inc_q) begin
						et_q          <= et_q + ETW'(1);
						rsp_q.entries <= 12'(et_q + ETW'(1));
					end else if (dec_q && et_q != '0) begin
						et_q          <= et_q - ETW'(1);
						rsp_q.entries <= 12'(et_q - ETW'(1));
					end
					rsp_q.status <= bhte_pkg::ST_OK;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_NRD: state_q <= S_NWR;
				S_NWR: begin
					et_q    <= et_wipe;
					state_q <= S_NLK;
				end
				S_NLK: begin
					ovf_q         <= ovf_q + NBW'(1);
					rsp_q.status  <= bhte_pkg::ST_OK;
					rsp_q.entries <= 12'(et_q);
					done_q        <= 1'b1;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request not taken");

	a_rec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != bhte_pkg::ST_OK |-> rsp.record_out == 64'd0)
		else $error("record on failed request");

	a_et_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(et_q) <= NS)
		else $error("entry count out of range");

endmodule
